[src/encoder_move_controller_top_assert.svh]
// Assertion macros used by the controller top
`ifndef ENCODER_MOVE_CONTROLLER_TOP_ASSERT_SVH
`define ENCODER_MOVE_CONTROLLER_TOP_ASSERT_SVH

// Check that a condition implies another one in the same cycle
`define EMC_ASSERT_SAME(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error("emc check failed: same-cycle implication");

// Check that a condition implies another one in the next cycle
`define EMC_ASSERT_NEXT(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error("emc check failed: next-cycle implication");

`endif

[src/emc_pkg.sv]
package emc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int PWM_MAX     = 255;
	localparam int MAG_W       = 8;
	localparam int GAIN_W      = 8;
	localparam int CMD_W       = COUNT_WIDTH + 11;
	localparam int TMO_W       = 16;
	localparam int EL_W        = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 24;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_MOVE   = 2'd1,
		PH_BRAKE  = 2'd2,
		PH_SETTLE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FWD   = 2'd0,
		KIND_BWD   = 2'd1,
		KIND_RIGHT = 2'd2,
		KIND_LEFT  = 2'd3
	} kind_t;

	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN      = 3'd0,
		REG_SPIN_PWM  = 3'd1,
		REG_STR_TMO   = 3'd2,
		REG_TURN_TMO  = 3'd3,
		REG_BRAKE_MS  = 3'd4,
		REG_SETTLE_MS = 3'd5,
		REG_BRAKE_PWM = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_q8;
		logic [MAG_W-1:0]  spin_pwm;
		logic [TMO_W-1:0]  straight_timeout_ms;
		logic [TMO_W-1:0]  turn_timeout_ms;
		logic [7:0]        brake_ms;
		logic [7:0]        settle_ms;
		logic [MAG_W-1:0]  brake_pwm;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  move_kind;
		logic [15:0] target_counts;
		logic [7:0]  drive_speed;
		logic        left_pulse;
		logic        right_pulse;
		logic        ms_tick;
	} item_t;

	typedef struct packed {
		phase_t                 phase;
		kind_t                  kind;
		logic [COUNT_WIDTH-1:0] left_count;
		logic [COUNT_WIDTH-1:0] right_count;
		logic [15:0]            goal_counts;
		logic [7:0]             base_speed;
		logic [EL_W-1:0]        elapsed_ms;
		logic                   timeout_flag;
	} status_t;

	typedef struct packed {
		logic [1:0]       dir;
		logic [MAG_W-1:0] mag;
	} motor_t;

	// Clamp a signed command to the pwm range and split it
	function automatic motor_t split_cmd(input logic signed [CMD_W-1:0] cmd);
		motor_t m;
		logic signed [CMD_W-1:0] lim;
		logic signed [CMD_W-1:0] c;
		logic signed [CMD_W-1:0] a;
		lim = CMD_W'(PWM_MAX);
		c = cmd;
		if (c > lim) c = lim;
		if (c < -lim) c = -lim;
		a = (c < 0) ? -c : c;
		if (c > 0) m.dir = DIR_FWD;
		else if (c < 0) m.dir = DIR_REV;
		else m.dir = DIR_OFF;
		m.mag = a[MAG_W-1:0];
		return m;
	endfunction

endpackage

[src/encoder_move_controller_top.sv]
// Each item is held in the input register and then in the result register.
// Throughput: one item per cycle; the input register and the result register
// each take a new item whenever the result register is empty or drained.
// Reset: arst_n clears the move state to idle, the pipeline valid flags and
// the configuration registers to their default values.
`include "encoder_move_controller_top_assert.svh"

module encoder_move_controller_top
	import emc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [1:0] move_kind, [17:2] target_counts, [25:18] drive_speed,
	// [26] left_pulse, [27] right_pulse, [28] ms_tick, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [0] req_type
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [1:0] left_dir, [9:2] left_mag, [11:10] right_dir, [19:12] right_mag,
	// [20] busy_res, [21] move_done, [22] timed_out, [23] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	status_t st_nxt;
	logic    done;
	motor_t  left_m;
	motor_t  right_m;
	logic    res_valid_s2;
	logic [OUT_DATA_W-1:0] res_s2;

	// Move on when the result register is free or being drained
	assign advance = valid_s1 && (!res_valid_s2 || m_tready);

	emc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	emc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.st_nxt (st_nxt),
		.done   (done)
	);

	emc_cmd u_cmd (
		.st      (st_nxt),
		.cfg     (cfg_q),
		.left_m  (left_m),
		.right_m (right_m)
	);

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_q8             <= 8'd205;
			cfg_q.spin_pwm            <= 8'd180;
			cfg_q.straight_timeout_ms <= 16'd4000;
			cfg_q.turn_timeout_ms     <= 16'd3000;
			cfg_q.brake_ms            <= 8'd40;
			cfg_q.settle_ms           <= 8'd40;
			cfg_q.brake_pwm           <= 8'd40;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN:      cfg_q.gain_q8             <= cfg_data[7:0];
				REG_SPIN_PWM:  cfg_q.spin_pwm            <= cfg_data[7:0];
				REG_STR_TMO:   cfg_q.straight_timeout_ms <= cfg_data;
				REG_TURN_TMO:  cfg_q.turn_timeout_ms     <= cfg_data;
				REG_BRAKE_MS:  cfg_q.brake_ms            <= cfg_data[7:0];
				REG_SETTLE_MS: cfg_q.settle_ms           <= cfg_data[7:0];
				REG_BRAKE_PWM: cfg_q.brake_pwm           <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= {1'b0, st_nxt.timeout_flag, done, (st_nxt.phase != PH_IDLE),
				right_m.mag, right_m.dir, left_m.mag, left_m.dir};
		end
	end

	assign m_tvalid = res_valid_s2;
	assign m_tdata  = res_s2;

	// Checks
	`EMC_ASSERT_SAME(a_done_not_busy, m_tvalid && m_tdata[21], !m_tdata[20])
	`EMC_ASSERT_SAME(a_left_off_zero, m_tvalid && m_tdata[1:0] == DIR_OFF, m_tdata[9:2] == '0)
	`EMC_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, valid_s1)
	`EMC_ASSERT_NEXT(a_advance_fills, advance, m_tvalid)

endmodule

[src/emc_in_reg.sv]
module emc_in_reg
	import emc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 advance,
	output logic                 valid_s1,
	output item_t                item_s1
);

	logic valid_q;

	// Accept when empty or when the held item moves on this cycle
	assign s_tready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// Unpack the payload into the item register
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type      <= s_tuser;
			item_s1.move_kind     <= s_tdata[1:0];
			item_s1.target_counts <= s_tdata[17:2];
			item_s1.drive_speed   <= s_tdata[25:18];
			item_s1.left_pulse    <= s_tdata[26];
			item_s1.right_pulse   <= s_tdata[27];
			item_s1.ms_tick       <= s_tdata[28];
		end
	end

endmodule

[src/emc_seq.sv]
module emc_seq
	import emc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output status_t st_nxt,
	output logic    done
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [EL_W-1:0]        EL_MAX  = '1;

	status_t st_q;
	logic [COUNT_WIDTH-1:0] l_new;
	logic [COUNT_WIDTH-1:0] r_new;
	logic [EL_W-1:0]        e_new;
	logic [TMO_W-1:0]       limit;

	// Saturating increments and timeout limit for this item
	always_comb begin
		l_new = st_q.left_count;
		r_new = st_q.right_count;
		e_new = st_q.elapsed_ms;
		if (item.left_pulse && st_q.left_count != CNT_MAX) l_new = st_q.left_count + 1'b1;
		if (item.right_pulse && st_q.right_count != CNT_MAX) r_new = st_q.right_count + 1'b1;
		if (item.ms_tick && st_q.elapsed_ms != EL_MAX) e_new = st_q.elapsed_ms + 1'b1;
		limit = (st_q.kind == KIND_FWD || st_q.kind == KIND_BWD) ?
			cfg.straight_timeout_ms : cfg.turn_timeout_ms;
	end

	// Next state and end-of-settle pulse
	always_comb begin
		st_nxt = st_q;
		done = 1'b0;
		if (item.req_type) begin
			if (st_q.phase == PH_IDLE) begin
				st_nxt.kind         = kind_t'(item.move_kind);
				st_nxt.goal_counts  = item.target_counts;
				st_nxt.base_speed   = item.drive_speed;
				st_nxt.left_count   = '0;
				st_nxt.right_count  = '0;
				st_nxt.elapsed_ms   = '0;
				st_nxt.timeout_flag = 1'b0;
				st_nxt.phase        = PH_MOVE;
			end
		end else begin
			unique case (st_q.phase)
				PH_IDLE: begin
				end
				PH_MOVE: begin
					st_nxt.left_count  = l_new;
					st_nxt.right_count = r_new;
					st_nxt.elapsed_ms  = e_new;
					if (l_new >= COUNT_WIDTH'(st_q.goal_counts)
							&& r_new >= COUNT_WIDTH'(st_q.goal_counts)) begin
						st_nxt.phase      = PH_BRAKE;
						st_nxt.elapsed_ms = '0;
					end else if (e_new > limit) begin
						st_nxt.timeout_flag = 1'b1;
						st_nxt.phase        = PH_BRAKE;
						st_nxt.elapsed_ms   = '0;
					end
				end
				PH_BRAKE: begin
					st_nxt.elapsed_ms = e_new;
					if (e_new >= EL_W'(cfg.brake_ms)) begin
						st_nxt.phase      = PH_SETTLE;
						st_nxt.elapsed_ms = '0;
					end
				end
				PH_SETTLE: begin
					st_nxt.elapsed_ms = e_new;
					if (e_new >= EL_W'(cfg.settle_ms)) begin
						st_nxt.phase      = PH_IDLE;
						st_nxt.elapsed_ms = '0;
						done              = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Commit the state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase        <= PH_IDLE;
			st_q.kind         <= KIND_FWD;
			st_q.left_count   <= '0;
			st_q.right_count  <= '0;
			st_q.goal_counts  <= '0;
			st_q.base_speed   <= '0;
			st_q.elapsed_ms   <= '0;
			st_q.timeout_flag <= 1'b0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

endmodule

[src/emc_cmd.sv]
module emc_cmd
	import emc_pkg::*;
(
	input  status_t st,
	input  cfg_t    cfg,
	output motor_t  left_m,
	output motor_t  right_m
);

	logic signed [COUNT_WIDTH:0]        err;
	logic [COUNT_WIDTH-1:0]             aerr;
	logic [COUNT_WIDTH+GAIN_W-1:0]      prod;
	logic signed [CMD_W-1:0]            adj;
	logic signed [CMD_W-1:0]            spd;
	logic signed [CMD_W-1:0]            turn;
	logic signed [CMD_W-1:0]            brake;

	// Proportional sync term, truncated toward zero, and the speed, turn and brake commands
	always_comb begin
		err  = $signed({1'b0, st.left_count}) - $signed({1'b0, st.right_count});
		aerr = err[COUNT_WIDTH] ? COUNT_WIDTH'(-err) : err[COUNT_WIDTH-1:0];
		prod = aerr * cfg.gain_q8;
		adj  = $signed(CMD_W'(prod >> GAIN_W));
		if (err[COUNT_WIDTH]) adj = -adj;
		spd   = $signed(CMD_W'(st.base_speed));
		if (st.kind == KIND_BWD) spd = -spd;
		turn  = $signed(CMD_W'(cfg.spin_pwm));
		brake = $signed(CMD_W'(cfg.brake_pwm));
	end

	// Select the wheel commands by phase and move kind
	always_comb begin
		left_m  = '{dir: DIR_OFF, mag: '0};
		right_m = '{dir: DIR_OFF, mag: '0};
		unique case (st.phase)
			PH_MOVE: begin
				unique case (st.kind)
					KIND_FWD, KIND_BWD: begin
						left_m  = split_cmd(spd - adj);
						right_m = split_cmd(spd + adj);
					end
					KIND_RIGHT: begin
						left_m  = split_cmd(turn);
						right_m = split_cmd(-turn);
					end
					KIND_LEFT: begin
						left_m  = split_cmd(-turn);
						right_m = split_cmd(turn);
					end
					default: begin
					end
				endcase
			end
			PH_BRAKE: begin
				left_m  = split_cmd(-brake);
				right_m = split_cmd(-brake);
			end
			PH_IDLE, PH_SETTLE: begin
			end
			default: begin
			end
		endcase
	end

endmodule
